[rtl/prp_pkg.sv]
// Shared constants, register indexes and the arctangent table for the point projector.
package prp_pkg;

   localparam int COORD_FRAC_BITS_DEF = 16;
   localparam int ANGLE_BITS_DEF = 12;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 31;

   localparam int CORDIC_STEPS = 30;
   localparam int STEP_W = 5;
   localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sh26DD3B6A;

   localparam logic [30:0] FOV_RESET = 31'd16777216;
   localparam logic [12:0] SCREEN_W_RESET = 13'd1280;
   localparam logic [12:0] SCREEN_H_RESET = 13'd720;
   localparam logic [15:0] GRID_RESET = 16'd129;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_YAW    = 3'd0,
      REG_PITCH  = 3'd1,
      REG_FOV    = 3'd2,
      REG_SCR_W  = 3'd3,
      REG_SCR_H  = 3'd4,
      REG_GRID   = 3'd5
   } reg_index_type;

   // Arctangent of 2^-i as a fraction of a full turn scaled to 2^32.
   function automatic logic [31:0] prp_atan(input logic [STEP_W-1:0] idx);
      logic [31:0] val;
      unique case (idx)
         5'd0:  val = 32'h20000000;
         5'd1:  val = 32'h12E4051E;
         5'd2:  val = 32'h09FB385B;
         5'd3:  val = 32'h051111D4;
         5'd4:  val = 32'h028B0D43;
         5'd5:  val = 32'h0145D7E1;
         5'd6:  val = 32'h00A2F61E;
         5'd7:  val = 32'h00517C55;
         5'd8:  val = 32'h0028BE53;
         5'd9:  val = 32'h00145F2F;
         5'd10: val = 32'h000A2F98;
         5'd11: val = 32'h000517CC;
         5'd12: val = 32'h00028BE6;
         5'd13: val = 32'h000145F3;
         5'd14: val = 32'h0000A2FA;
         5'd15: val = 32'h0000517D;
         5'd16: val = 32'h000028BE;
         5'd17: val = 32'h0000145F;
         5'd18: val = 32'h00000A30;
         5'd19: val = 32'h00000518;
         5'd20: val = 32'h0000028C;
         5'd21: val = 32'h00000146;
         5'd22: val = 32'h000000A3;
         5'd23: val = 32'h00000051;
         5'd24: val = 32'h00000029;
         5'd25: val = 32'h00000014;
         5'd26: val = 32'h0000000A;
         5'd27: val = 32'h00000005;
         5'd28: val = 32'h00000003;
         5'd29: val = 32'h00000001;
         default: val = 32'h00000000;
      endcase
      return val;
   endfunction

endpackage

[rtl/prp_trig.sv]
// Iterative CORDIC that turns one angle register into its cosine and sine in Q1.30.
module prp_trig #(
   parameter int ANGLE_BITS = prp_pkg::ANGLE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [ANGLE_BITS-1:0]    angle,
   output logic                     busy,
   output logic signed [31:0]       cos_val,
   output logic signed [31:0]       sin_val
);
   import prp_pkg::*;

   logic                     busy_ff;
   logic [STEP_W-1:0]        step_ff;
   logic signed [33:0]       x_ff, y_ff;
   logic signed [32:0]       z_ff;
   logic                     flip_ff;
   logic signed [31:0]       cos_ff, sin_ff;

   logic [31:0]              phase;
   logic                     flip_in;
   logic [31:0]              phase_adj;
   logic signed [33:0]       dx, dy;
   logic signed [32:0]       turn;
   logic signed [33:0]       x_in, y_in;
   logic signed [32:0]       z_in;

   always_comb begin
      phase = {angle, {(32-ANGLE_BITS){1'b0}}};
      flip_in = phase[31] ^ phase[30];
      phase_adj = flip_in ? (phase + 32'h8000_0000) : phase;
      dx = y_ff >>> step_ff;
      dy = x_ff >>> step_ff;
      turn = $signed({1'b0, prp_atan(step_ff)});
      if (z_ff >= 0) begin
         x_in = x_ff - dx;
         y_in = y_ff + dy;
         z_in = z_ff - turn;
      end else begin
         x_in = x_ff + dx;
         y_in = y_ff - dy;
         z_in = z_ff + turn;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + 1'b1;
         if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff <= CORDIC_GAIN_INV;
         y_ff <= '0;
         z_ff <= $signed({phase_adj[31], phase_adj});
         flip_ff <= flip_in;
      end else if (busy_ff) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
         if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
            cos_ff <= flip_ff ? 32'(-x_in) : 32'(x_in);
            sin_ff <= flip_ff ? 32'(-y_in) : 32'(y_in);
         end
      end
   end

   assign busy = start | busy_ff;
   assign cos_val = cos_ff;
   assign sin_val = sin_ff;

endmodule

[rtl/prp_rotate.sv]
// Two-stage plane rotation: four products, then floor shift by 30 and clamp.
module prp_rotate (
   input  logic               clock,
   input  logic               en,
   input  logic signed [32:0] a,
   input  logic signed [32:0] b,
   input  logic signed [31:0] c,
   input  logic signed [31:0] s,
   output logic signed [32:0] oa,
   output logic signed [32:0] ob
);
   localparam logic signed [35:0] ROT_MAX = 36'sd4294967295;
   localparam logic signed [35:0] ROT_MIN = -36'sd4294967295;

   logic signed [64:0] ca_ff, sb_ff, sa_ff, cb_ff;
   logic signed [32:0] oa_ff, ob_ff;
   logic signed [65:0] sum_a, sum_b;
   logic signed [35:0] sh_a, sh_b;
   logic signed [32:0] oa_in, ob_in;

   always_comb begin
      sum_a = {ca_ff[64], ca_ff} - {sb_ff[64], sb_ff};
      sum_b = {sa_ff[64], sa_ff} + {cb_ff[64], cb_ff};
      sh_a = sum_a[65:30];
      sh_b = sum_b[65:30];
      if (sh_a > ROT_MAX) oa_in = 33'(ROT_MAX);
      else if (sh_a < ROT_MIN) oa_in = 33'(ROT_MIN);
      else oa_in = 33'(sh_a);
      if (sh_b > ROT_MAX) ob_in = 33'(ROT_MAX);
      else if (sh_b < ROT_MIN) ob_in = 33'(ROT_MIN);
      else ob_in = 33'(sh_b);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ca_ff <= a * c;
         sb_ff <= b * s;
         sa_ff <= a * s;
         cb_ff <= b * c;
         oa_ff <= oa_in;
         ob_ff <= ob_in;
      end
   end

   assign oa = oa_ff;
   assign ob = ob_ff;

endmodule

[rtl/prp_div_pipe.sv]
// Two-lane unsigned restoring divider with one quotient bit per pipeline stage.
module prp_div_pipe #(
   parameter int NW = 64,
   parameter int DW = 33,
   parameter int SW = 3
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num0,
   input  logic [NW-1:0] in_num1,
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [NW-1:0] out_quot0,
   output logic [NW-1:0] out_quot1,
   output logic [SW-1:0] out_side
);
   logic [NW-1:0] nq_ff   [NW][2];
   logic [DW-1:0] rem_ff  [NW][2];
   logic [DW-1:0] den_ff  [NW];
   logic [SW-1:0] side_ff [NW];
   logic          valid_ff[NW];

   for (genvar st = 0; st < NW; st++) begin : g_stage
      logic [NW-1:0] nq_prev  [2];
      logic [DW-1:0] rem_prev [2];
      logic [DW-1:0] den_prev;
      logic [SW-1:0] side_prev;
      logic          valid_prev;

      if (st == 0) begin : g_first
         assign nq_prev[0] = in_num0;
         assign nq_prev[1] = in_num1;
         assign rem_prev[0] = '0;
         assign rem_prev[1] = '0;
         assign den_prev = in_den;
         assign side_prev = in_side;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign nq_prev[0] = nq_ff[st-1][0];
         assign nq_prev[1] = nq_ff[st-1][1];
         assign rem_prev[0] = rem_ff[st-1][0];
         assign rem_prev[1] = rem_ff[st-1][1];
         assign den_prev = den_ff[st-1];
         assign side_prev = side_ff[st-1];
         assign valid_prev = valid_ff[st-1];
      end

      for (genvar ln = 0; ln < 2; ln++) begin : g_lane
         logic [DW:0]   shifted;
         logic          ge;
         logic [DW:0]   diff;

         always_comb begin
            shifted = {rem_prev[ln], nq_prev[ln][NW-1]};
            ge = shifted >= {1'b0, den_prev};
            diff = shifted - {1'b0, den_prev};
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[st][ln] <= ge ? diff[DW-1:0] : shifted[DW-1:0];
               nq_ff[st][ln] <= {nq_prev[ln][NW-2:0], ge};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[st] <= den_prev;
            side_ff[st] <= side_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[st] <= 1'b0;
         end else if (en) begin
            valid_ff[st] <= valid_prev;
         end
      end
   end

   assign out_valid = valid_ff[NW-1];
   assign out_quot0 = nq_ff[NW-1][0];
   assign out_quot1 = nq_ff[NW-1][1];
   assign out_side = side_ff[NW-1];

endmodule

[rtl/point_rotate_project.sv]
// Point rotator and perspective projector, one item per cycle while the output
// is not stalled and neither CORDIC unit is busy. An accepted item passes the
// yaw and pitch rotations, setup, the perspective divider, the scale stage, the
// grid divider and the output register. After reset and after each angle write,
// req_tready is low while the CORDIC unit runs. Reset is synchronous,
// active high, and restores the register defaults and empties the pipeline.
module point_rotate_project #(
   parameter int COORD_FRAC_BITS = prp_pkg::COORD_FRAC_BITS_DEF,
   parameter int ANGLE_BITS = prp_pkg::ANGLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // Input items. tdata: pos_x [31:0], pos_y [63:32], pos_z [95:64].
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [95:0]                   req_tdata,
   // Result items. tdata: screen_x [15:0], screen_y [31:16].
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [31:0]                   rsp_tdata,
   // tuser: behind_camera [0].
   output logic [0:0]                    rsp_tuser,
   // Register writes.
   input  logic                          csr_we,
   input  logic [prp_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [prp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import prp_pkg::*;

   localparam int F = COORD_FRAC_BITS;
   localparam int RW = F + 18;
   localparam int SW = F + 20;
   localparam logic [RW-1:0] R_LIM = RW'(1) << (F + 17);

   // Configuration registers.
   logic [ANGLE_BITS-1:0] yaw_ff, pitch_ff;
   logic [30:0]           fov_ff;
   logic [12:0]           scr_w_ff, scr_h_ff;
   logic [15:0]           grid_ff;
   logic                  yaw_start_ff, pitch_start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_ff <= '0;
         pitch_ff <= '0;
         fov_ff <= FOV_RESET;
         scr_w_ff <= SCREEN_W_RESET;
         scr_h_ff <= SCREEN_H_RESET;
         grid_ff <= GRID_RESET;
         yaw_start_ff <= 1'b1;
         pitch_start_ff <= 1'b1;
      end else begin
         yaw_start_ff <= 1'b0;
         pitch_start_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_addr)
               REG_YAW: begin
                  yaw_ff <= csr_wdata[ANGLE_BITS-1:0];
                  yaw_start_ff <= 1'b1;
               end
               REG_PITCH: begin
                  pitch_ff <= csr_wdata[ANGLE_BITS-1:0];
                  pitch_start_ff <= 1'b1;
               end
               REG_FOV:   fov_ff <= csr_wdata;
               REG_SCR_W: scr_w_ff <= csr_wdata[12:0];
               REG_SCR_H: scr_h_ff <= csr_wdata[12:0];
               REG_GRID:  grid_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
   end

   // Sine and cosine depend only on the angle registers, so they are
   // computed once per write by a shared iterative CORDIC per axis.
   logic               yaw_busy, pitch_busy;
   logic signed [31:0] cos_yaw, sin_yaw, cos_pitch, sin_pitch;

   prp_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_yaw (
      .clock(clock), .reset(reset), .start(yaw_start_ff), .angle(yaw_ff),
      .busy(yaw_busy), .cos_val(cos_yaw), .sin_val(sin_yaw)
   );

   prp_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_pitch (
      .clock(clock), .reset(reset), .start(pitch_start_ff), .angle(pitch_ff),
      .busy(pitch_busy), .cos_val(cos_pitch), .sin_val(sin_pitch)
   );

   // The whole pipeline moves together whenever the output register is
   // empty or being emptied, so a stall holds every stage in place.
   logic pipe_en;
   logic rsp_valid_ff;
   logic in_take;

   assign pipe_en = !rsp_valid_ff || rsp_tready;
   assign req_tready = pipe_en && !yaw_busy && !pitch_busy;
   assign in_take = req_tvalid && req_tready;

   logic signed [31:0] pos_x, pos_y, pos_z;
   assign pos_x = req_tdata[31:0];
   assign pos_y = req_tdata[63:32];
   assign pos_z = req_tdata[95:64];

   // Yaw rotation (stages 1-2) carries y alongside.
   logic [3:0]         rot_valid_ff;
   logic signed [31:0] y_d1_ff, y_d2_ff;
   logic signed [32:0] x1, z1, x1_d3_ff, x1_d4_ff, y2, z2;

   prp_rotate u_rot_yaw (
      .clock(clock), .en(pipe_en),
      .a({pos_x[31], pos_x}), .b({pos_z[31], pos_z}),
      .c(cos_yaw), .s(sin_yaw), .oa(x1), .ob(z1)
   );

   // Pitch rotation (stages 3-4) carries x1 alongside.
   prp_rotate u_rot_pitch (
      .clock(clock), .en(pipe_en),
      .a({y_d2_ff[31], y_d2_ff}), .b(z1),
      .c(cos_pitch), .s(sin_pitch), .oa(y2), .ob(z2)
   );

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         y_d1_ff <= pos_y;
         y_d2_ff <= y_d1_ff;
         x1_d3_ff <= x1;
         x1_d4_ff <= x1_d3_ff;
      end
   end

   // Stage 5: denominator and perspective numerators.
   logic               s5_valid_ff;
   logic signed [33:0] d_ff;
   logic signed [64:0] nx_ff, ny_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         d_ff <= $signed({3'b000, fov_ff}) + {z2[32], z2};
         nx_ff <= $signed({1'b0, fov_ff}) * x1_d4_ff;
         ny_ff <= $signed({1'b0, fov_ff}) * y2;
      end
   end

   // Stage 6: magnitudes, signs and the behind-camera test. A point behind
   // the camera divides by one and its result is forced to zero at the end.
   logic               s6_valid_ff;
   logic [63:0]        mag_x_ff, mag_y_ff;
   logic [32:0]        den_ff;
   logic [2:0]         side6_ff;
   logic               behind_in;

   assign behind_in = (d_ff <= 0);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         mag_x_ff <= nx_ff[64] ? 64'(-nx_ff) : nx_ff[63:0];
         mag_y_ff <= ny_ff[64] ? 64'(-ny_ff) : ny_ff[63:0];
         den_ff <= behind_in ? 33'd1 : d_ff[32:0];
         side6_ff <= {behind_in, ny_ff[64], nx_ff[64]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_valid_ff <= '0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rot_valid_ff <= {rot_valid_ff[2:0], in_take};
         s5_valid_ff <= rot_valid_ff[3];
         s6_valid_ff <= s5_valid_ff;
      end
   end

   // Perspective division |fov*v| / d, one bit per stage.
   logic        dv1_valid;
   logic [63:0] qx, qy;
   logic [2:0]  dv1_side;

   prp_div_pipe #(.NW(64), .DW(33), .SW(3)) u_div_persp (
      .clock(clock), .reset(reset), .en(pipe_en),
      .in_valid(s6_valid_ff), .in_num0(mag_x_ff), .in_num1(mag_y_ff),
      .in_den(den_ff), .in_side(side6_ff),
      .out_valid(dv1_valid), .out_quot0(qx), .out_quot1(qy), .out_side(dv1_side)
   );

   // Scale by screen height; dividing the product by the grid side gives
   // the same pixels as the split quotient and remainder form.
   logic        sc_valid_ff;
   logic [76:0] mx_ff, my_ff;
   logic [2:0]  sc_side_ff;
   logic [15:0] grid_eff;

   assign grid_eff = (grid_ff == 16'd0) ? 16'd1 : grid_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         mx_ff <= 77'(qx) * 77'(scr_h_ff);
         my_ff <= 77'(qy) * 77'(scr_h_ff);
         sc_side_ff <= dv1_side;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         sc_valid_ff <= dv1_valid;
      end
   end

   logic        dv2_valid;
   logic [76:0] rx, ry;
   logic [2:0]  dv2_side;

   prp_div_pipe #(.NW(77), .DW(16), .SW(3)) u_div_grid (
      .clock(clock), .reset(reset), .en(pipe_en),
      .in_valid(sc_valid_ff), .in_num0(mx_ff), .in_num1(my_ff),
      .in_den(grid_eff), .in_side(sc_side_ff),
      .out_valid(dv2_valid), .out_quot0(rx), .out_quot1(ry), .out_side(dv2_side)
   );

   // Adds the half-screen offset, truncates toward zero to whole pixels
   // and saturates. Offsets past the clamp limit saturate in any case.
   function automatic logic [15:0] pixel_of(input logic [76:0] mag, input logic neg,
                                            input logic [11:0] half);
      logic [RW-1:0]        rc;
      logic signed [SW-1:0] off;
      logic signed [SW-1:0] sum;
      logic signed [SW-1:0] adj;
      logic signed [SW-1:0] pw;
      logic [15:0]          res;
      rc = (mag >= 77'(R_LIM)) ? R_LIM : mag[RW-1:0];
      off = $signed({2'b00, rc});
      sum = $signed({{(SW-12-F){1'b0}}, half, {F{1'b0}}}) + (neg ? -off : off);
      adj = sum[SW-1] ? (sum + SW'((2 ** F) - 1)) : sum;
      pw = adj >>> F;
      if (pw > 32767) res = 16'h7FFF;
      else if (pw < -32768) res = 16'h8000;
      else res = pw[15:0];
      return res;
   endfunction

   logic [15:0] sx_out_ff, sy_out_ff;
   logic        behind_out_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sx_out_ff <= dv2_side[2] ? 16'd0 : pixel_of(rx, dv2_side[0], scr_w_ff[12:1]);
         sy_out_ff <= dv2_side[2] ? 16'd0 : pixel_of(ry, dv2_side[1], scr_h_ff[12:1]);
         behind_out_ff <= dv2_side[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= dv2_valid;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {sy_out_ff, sx_out_ff};
   assign rsp_tuser = behind_out_ff;

endmodule

[tb/sv/point_rotate_project_test.sv]
// Self-checking testbench for the point rotator and perspective projector.
`timescale 1ns / 100ps

module point_rotate_project_test;
   import prp_pkg::*;

   // Register indexes past the end of the map; writes to them must be ignored.
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 200;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int PHASES = 10;

   typedef struct {
      logic signed [15:0] screen_x;
      logic signed [15:0] screen_y;
      logic               behind_camera;
   } pixel_type;

   // Projector model: holds its own copy of the registers and a queue of the
   // pixels still owed by the block, oldest first.
   class pixel_scoreboard;
      bit [11:0] yaw, pitch;
      bit [30:0] fov;
      bit [12:0] scr_w, scr_h;
      bit [15:0] grid;
      pixel_type pending[$];
      int        errors, checked, behind_seen;
      longint    atan_turns[30] = '{
         'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
         'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
         'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
         'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
         'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001};

      function void restore_defaults();
         yaw = 0;
         pitch = 0;
         fov = FOV_RESET;
         scr_w = SCREEN_W_RESET;
         scr_h = SCREEN_H_RESET;
         grid = GRID_RESET;
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            REG_YAW:   yaw = val[11:0];
            REG_PITCH: pitch = val[11:0];
            REG_FOV:   fov = val;
            REG_SCR_W: scr_w = val[12:0];
            REG_SCR_H: scr_h = val[12:0];
            REG_GRID:  grid = val[15:0];
            default: ;
         endcase
      endfunction

      // CORDIC in Q1.30; the phase is folded into the right half-plane first.
      function void trig(bit [11:0] ang, output longint cs, output longint sn);
         bit [31:0] phase;
         int        phase_s;
         bit        flip;
         longint    x, y, z, dx, dy;
         phase = {ang, 20'd0};
         flip = 0;
         if (((phase + 32'h40000000) & 32'h80000000) != 0) begin
            phase += 32'h80000000;
            flip = 1;
         end
         phase_s = phase;
         z = phase_s;
         x = 'h26DD3B6A;
         y = 0;
         for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= atan_turns[i];
            end else begin
               x += dx; y -= dy; z += atan_turns[i];
            end
         end
         cs = flip ? -x : x;
         sn = flip ? -y : y;
      endfunction

      function longint shift_clamp(longint v, longint lim);
         longint r;
         r = v >>> 30;
         if (r > lim) r = lim;
         if (r < -lim) r = -lim;
         return r;
      endfunction

      function logic signed [15:0] to_pixel(longint v, longint d, longint half);
         longint g, q, a, b, r, pix;
         g = (grid == 0) ? 1 : grid;
         q = (longint'(fov) * v) / d;
         a = q / g;
         if (a > 64'sd281474976710656) a = 64'sd281474976710656;
         if (a < -64'sd281474976710656) a = -64'sd281474976710656;
         b = q % g;
         r = a * longint'(scr_h) + (b * longint'(scr_h)) / g;
         pix = ((half >>> 1) <<< 16) + r;
         pix = pix / 65536;
         if (pix > 32767) pix = 32767;
         if (pix < -32768) pix = -32768;
         return pix[15:0];
      endfunction

      function void note_point(logic [95:0] pos);
         longint x, y, z, cy, sy, cp, sp, x1, z1, y2, z2, d;
         pixel_type pix;
         x = $signed(pos[31:0]);
         y = $signed(pos[63:32]);
         z = $signed(pos[95:64]);
         trig(yaw, cy, sy);
         trig(pitch, cp, sp);
         x1 = shift_clamp(cy * x - sy * z, 64'sd4294967295);
         z1 = shift_clamp(sy * x + cy * z, 64'sd4294967295);
         y2 = shift_clamp(cp * y - sp * z1, 64'sd4294967295);
         z2 = shift_clamp(sp * y + cp * z1, 64'sd4294967295);
         d = longint'(fov) + z2;
         if (d <= 0) begin
            pix = '{16'sd0, 16'sd0, 1'b1};
         end else begin
            pix.screen_x = to_pixel(x1, d, scr_w);
            pix.screen_y = to_pixel(y2, d, scr_h);
            pix.behind_camera = 1'b0;
         end
         pending.push_back(pix);
      endfunction

      function void check_pixel(logic [31:0] data, logic [0:0] user);
         pixel_type exp_pix;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h/%b", $time, data, user);
            errors++;
            return;
         end
         exp_pix = pending.pop_front();
         checked++;
         if (exp_pix.behind_camera) behind_seen++;
         if (data[15:0] !== exp_pix.screen_x) begin
            $display("%0t: screen_x expected %0d actual %0d", $time,
                     exp_pix.screen_x, $signed(data[15:0]));
            errors++;
         end
         if (data[31:16] !== exp_pix.screen_y) begin
            $display("%0t: screen_y expected %0d actual %0d", $time,
                     exp_pix.screen_y, $signed(data[31:16]));
            errors++;
         end
         if (user[0] !== exp_pix.behind_camera) begin
            $display("%0t: behind_camera expected %b actual %b", $time,
                     exp_pix.behind_camera, user[0]);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [95:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic csr_we = 0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   pixel_scoreboard sb = new();
   logic req_fire = 0;  // the item offered was taken at the last rising edge
   bit   quiet = 0;     // no idling on either side in the closing phase
   bit   sender_idles = 1;
   int   cycles = 0;
   int   results = 0;
   int   sent = 0;

   point_rotate_project dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Both channels are observed at the rising edge. The model takes every item
   // that the block accepts, and every result is checked against its queue.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      req_fire <= req_tvalid && req_tready && !reset;
      if (!reset && req_tvalid && req_tready) sb.note_point(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_pixel(rsp_tdata, rsp_tuser);
         results <= results + 1;
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("simulation failed");
         $finish;
      end
   end

   // Result side. Ready drops in random bursts, and once in the run it stays
   // low for a long stretch so that the pipeline backs up into the input.
   // The long stretch starts in the middle of a phase without sender idling,
   // while many items are still to be offered.
   initial begin : receiver
      int stall_left;
      bit long_done;
      stall_left = 0;
      long_done = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!long_done && sent >= 250) begin
            long_done = 1;
            stall_left = 700;
         end
         if (stall_left > 0) begin
            rsp_tready <= 0;
            stall_left--;
         end else if (!quiet && $urandom_range(7) == 0) begin
            rsp_tready <= 0;
            stall_left = $urandom_range(15);
         end else begin
            rsp_tready <= 1;
         end
         @(negedge clock);
      end
   end

   task automatic write_csr(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_we <= 1;
      csr_addr <= idx;
      csr_wdata <= val;
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_we <= 0;
   endtask

   // Offers one item and holds it until the block takes it; afterwards the
   // sender may go quiet for a short burst.
   task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      req_tvalid <= 1;
      req_tdata <= {z, y, x};
      do @(negedge clock); while (!req_fire);
      sent++;
      if (!quiet && sender_idles && $urandom_range(5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(16, 1)) @(negedge clock);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 0;
      do @(negedge clock); while (sb.pending.size() != 0);
   endtask

   // Coordinates: mostly terrain-sized values, some full range, and some z
   // values placed near the camera plane so that both sides of it are hit.
   function automatic logic [31:0] pick_coord(bit is_z);
      int mode;
      mode = $urandom_range(9);
      if (mode < 5) return $urandom_range(0, 400 << 16) - (200 << 16);
      if (mode < 8) return $urandom;
      if (is_z) return -int'(sb.fov) + int'($urandom_range(0, 1 << 18)) - (1 << 17);
      return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_fov();
      case ($urandom_range(4))
         0: return 31'd1;
         1: return 31'h7FFFFFFF;
         2: return $urandom;
         default: return $urandom_range(2000, 1) << 16;
      endcase
   endfunction

   initial begin
      sb.restore_defaults();
      repeat (5) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed items with the register defaults: extremes of each field,
      // the origin, and points behind the camera.
      send_point(0, 0, 0);
      send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send_point(32'h80000000, 32'h80000000, 32'h80000000);
      send_point(32'h80000000, 32'h7FFFFFFF, 0);
      send_point(32'h00640000, 32'hFF9C0000, 32'hFF000000);
      send_point(32'h00010000, 32'h00010000, 32'hFEFFFFFF);
      send_point(32'hFFFFFFFF, 32'h00000001, 32'h00000001);
      wait_idle();

      // Odd register values: wide angles, zero sizes, zero grid side, and
      // writes to indexes that do not exist.
      write_csr(REG_YAW, 31'h7FFFF400);
      write_csr(REG_PITCH, 31'h00000FFF);
      write_csr(REG_FOV, 31'h7FFFFFFF);
      write_csr(REG_SCR_W, 31'h00001FFF);
      write_csr(REG_SCR_H, 31'd0);
      write_csr(REG_GRID, 31'h00010000);
      write_csr(CSR_SPARE_LO, 31'd12345);
      write_csr(CSR_SPARE_HI, 31'h7FFFFFFF);
      send_point(0, 0, 0);
      send_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
      send_point(32'h00100000, 32'h00200000, 32'h80000000);
      wait_idle();
      write_csr(REG_FOV, 31'd1);
      write_csr(REG_GRID, 31'd1);
      write_csr(REG_SCR_H, 31'd8191);
      write_csr(REG_YAW, 31'd1024);
      send_point(0, 0, 0);
      send_point(32'h00000001, 32'hFFFFFFFF, 32'h00000000);
      send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF);
      wait_idle();

      for (int ph = 0; ph < PHASES; ph++) begin
         // Every phase rewrites all six registers, sometimes at their ends.
         write_csr(REG_YAW, $urandom_range(1) ? $urandom : 31'($urandom_range(1) * 4095));
         write_csr(REG_PITCH, $urandom_range(1) ? $urandom : 31'($urandom_range(1) * 4095));
         write_csr(REG_FOV, pick_fov());
         write_csr(REG_SCR_W, $urandom_range(3) == 0 ? 31'($urandom_range(1) * 4096 + 1)
                                                     : 31'($urandom_range(4096, 1)));
         write_csr(REG_SCR_H, $urandom_range(3) == 0 ? 31'($urandom_range(1) * 4095 + 1)
                                                     : 31'($urandom_range(4096, 1)));
         write_csr(REG_GRID, $urandom_range(3) == 0 ? 31'($urandom_range(1) ? 65535 : 1)
                                                    : 31'($urandom_range(300, 1)));
         sender_idles = (ph % 3 != 1);
         quiet = (ph == PHASES - 1);
         for (int i = 0; i < ITEMS_PER_PHASE; i++)
            send_point(pick_coord(0), pick_coord(0), pick_coord(1));
         // The sender waits here until every pixel owed has come back.
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("sent %0d points over %0d register settings, %0d pixels checked",
               sent, PHASES + 3, sb.checked);
      $display("%0d of them behind the camera, %0d mismatches", sb.behind_seen, sb.errors);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
